// File: src/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Types, constants and the charge-pump band lookup for the PLL solver.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int LANES      = 4;
    localparam int VCO_W      = 12;
    localparam int REF_W      = 9;
    localparam int FOUT_W     = 12;
    localparam int DIV_W      = 2;
    localparam int NPC_W      = 6;
    localparam int CODE_W     = 4;
    localparam int STEP_BITS  = 4;
    localparam int WIDE_W     = FOUT_W + 3;

    localparam logic [REF_W-1:0]  REF_RESET = 9'd24;
    localparam logic [WIDE_W-1:0] VCO_MIN   = 15'd1200;
    localparam logic [WIDE_W-1:0] VCO_MAX   = 15'd2700;

    localparam logic [VCO_W-1:0] BAND_12 = 12'd2650;
    localparam logic [VCO_W-1:0] BAND_10 = 12'd2480;
    localparam logic [VCO_W-1:0] BAND_9  = 12'd2300;
    localparam logic [VCO_W-1:0] BAND_7  = 12'd2080;
    localparam logic [VCO_W-1:0] BAND_6  = 12'd1870;
    localparam logic [VCO_W-1:0] BAND_4  = 12'd1600;

    localparam logic [CODE_W-1:0] CIH_12 = 4'b1100;
    localparam logic [CODE_W-1:0] CIH_10 = 4'b1010;
    localparam logic [CODE_W-1:0] CIH_9  = 4'b1001;
    localparam logic [CODE_W-1:0] CIH_7  = 4'b0111;
    localparam logic [CODE_W-1:0] CIH_6  = 4'b0110;
    localparam logic [CODE_W-1:0] CIH_4  = 4'b0100;
    localparam logic [CODE_W-1:0] CIH_3  = 4'b0011;

    localparam logic STATUS_FOUND    = 1'b0;
    localparam logic STATUS_NO_FOUND = 1'b1;

    typedef struct packed {
        logic             ok;
        logic [VCO_W-1:0] vco;
        logic [VCO_W-1:0] num;
        logic [REF_W-1:0] rem;
        logic [VCO_W-1:0] quo;
    } lane_t;

    typedef lane_t [LANES-1:0] lane_vec_t;

    // vco is above VCO_MIN here; at or below BAND_4 it maps to CIH_3
    function automatic logic [CODE_W-1:0] cih_lookup(input logic [VCO_W-1:0] vco);
        logic [CODE_W-1:0] code;
        if (vco > BAND_12)
            code = CIH_12;
        else if (vco > BAND_10)
            code = CIH_10;
        else if (vco > BAND_9)
            code = CIH_9;
        else if (vco > BAND_7)
            code = CIH_7;
        else if (vco > BAND_6)
            code = CIH_6;
        else if (vco > BAND_4)
            code = CIH_4;
        else
            code = CIH_3;
        return code;
    endfunction

endpackage

// File: src/pps_div_stage.sv
// ----------------------------------------------------------------------------
// pps_div_stage
// One registered slice of the lane dividers: four restoring steps per lane.
// ----------------------------------------------------------------------------
module pps_div_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  pps_pkg::lane_vec_t           in_lanes,
    input  logic [pps_pkg::REF_W-1:0]    divisor,
    input  logic                         out_ready,
    output logic                         in_ready,
    output logic                         valid_reg,
    output pps_pkg::lane_vec_t           lanes_reg
);
    import pps_pkg::*;

    lane_vec_t lanes_next;

    always_comb
    begin
        logic [REF_W:0] trial;
        lanes_next = in_lanes;
        for (int l = 0; l < LANES; l++)
        begin
            for (int s = 0; s < STEP_BITS; s++)
            begin
                trial = {lanes_next[l].rem, lanes_next[l].num[VCO_W-1]};
                lanes_next[l].num = {lanes_next[l].num[VCO_W-2:0], 1'b0};
                if (trial >= {1'b0, divisor})
                begin
                    trial = trial - {1'b0, divisor};
                    lanes_next[l].rem = trial[REF_W-1:0];
                    lanes_next[l].quo = {lanes_next[l].quo[VCO_W-2:0], 1'b1};
                end
                else
                begin
                    lanes_next[l].rem = trial[REF_W-1:0];
                    lanes_next[l].quo = {lanes_next[l].quo[VCO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            lanes_reg <= lanes_next;
    end

endmodule

// File: src/pll_parameter_solver_top.sv
// ----------------------------------------------------------------------------
// pll_parameter_solver_top
// PLL divider search: four divider lanes, pipelined division, band lookup.
// Items pass the s0 register, three divider stages and the output register.
// One item per cycle unless stalled; the 12-bit quotient spans 3 stages.
// A stalled output holds the whole pipeline; no item is lost or repeated.
// Reset clears all valid bits and loads the reference register with 24 MHz.
// ----------------------------------------------------------------------------
module pll_parameter_solver_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pps_pkg::REF_W-1:0]     cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pps_pkg::FOUT_W-1:0]    out_freq_mhz,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          status,
    output logic [pps_pkg::DIV_W-1:0]     out_div,
    output logic [pps_pkg::NPC_W-1:0]     npc_code,
    output logic [pps_pkg::CODE_W-1:0]    nsc_code,
    output logic [pps_pkg::CODE_W-1:0]    cih_code
);
    import pps_pkg::*;

    logic [REF_W-1:0] ref_reg;

    logic      s0_valid_reg;
    lane_vec_t s0_lanes_reg;
    lane_vec_t s0_lanes_next;
    logic      s0_ready;

    logic      st1_in_ready, st1_valid;
    logic      st2_in_ready, st2_valid;
    logic      st3_in_ready, st3_valid;
    lane_vec_t st1_lanes, st2_lanes, st3_lanes;

    logic out_valid_reg;
    logic out_ready;

    logic                status_reg, status_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [NPC_W-1:0]    npc_reg, npc_next;
    logic [CODE_W-1:0]   nsc_reg, nsc_next;
    logic [CODE_W-1:0]   cih_reg, cih_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ref_reg <= REF_RESET;
        else if (cfg_wr_en)
            ref_reg <= cfg_wr_data;
    end

    // lane l tries output divider exponent l
    always_comb
    begin
        logic [WIDE_W-1:0] wide;
        for (int l = 0; l < LANES; l++)
        begin
            wide = {3'b000, out_freq_mhz} << l;
            s0_lanes_next[l].ok  = (wide > VCO_MIN) && (wide <= VCO_MAX) && (ref_reg != '0);
            s0_lanes_next[l].vco = wide[VCO_W-1:0];
            s0_lanes_next[l].num = wide[VCO_W-1:0];
            s0_lanes_next[l].rem = '0;
            s0_lanes_next[l].quo = '0;
        end
    end

    assign out_ready = !out_valid_reg || !out_stall;
    assign s0_ready  = !s0_valid_reg || st1_in_ready;
    assign in_stall  = !s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s0_ready)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
            s0_lanes_reg <= s0_lanes_next;
    end

    pps_div_stage u_st1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_lanes  (s0_lanes_reg),
        .divisor   (ref_reg),
        .out_ready (st2_in_ready),
        .in_ready  (st1_in_ready),
        .valid_reg (st1_valid),
        .lanes_reg (st1_lanes)
    );

    pps_div_stage u_st2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st1_valid),
        .in_lanes  (st1_lanes),
        .divisor   (ref_reg),
        .out_ready (st3_in_ready),
        .in_ready  (st2_in_ready),
        .valid_reg (st2_valid),
        .lanes_reg (st2_lanes)
    );

    pps_div_stage u_st3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st2_valid),
        .in_lanes  (st2_lanes),
        .divisor   (ref_reg),
        .out_ready (out_ready),
        .in_ready  (st3_in_ready),
        .valid_reg (st3_valid),
        .lanes_reg (st3_lanes)
    );

    // highest divider exponent with an exact quotient wins
    always_comb
    begin
        logic [VCO_W-1:0] fb_m4;
        status_next = STATUS_NO_FOUND;
        div_next    = '0;
        npc_next    = '0;
        nsc_next    = '0;
        cih_next    = '0;
        fb_m4       = '0;
        for (int l = 0; l < LANES; l++)
        begin
            if (st3_lanes[l].ok && (st3_lanes[l].rem == '0))
            begin
                fb_m4       = st3_lanes[l].quo - VCO_W'(4);
                status_next = STATUS_FOUND;
                div_next    = DIV_W'(l);
                npc_next    = fb_m4[NPC_W+1:2];
                nsc_next    = {2'b01, st3_lanes[l].quo[1:0]};
                cih_next    = cih_lookup(st3_lanes[l].vco);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= st3_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && st3_valid)
        begin
            status_reg <= status_next;
            div_reg    <= div_next;
            npc_reg    <= npc_next;
            nsc_reg    <= nsc_next;
            cih_reg    <= cih_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_div   = div_reg;
    assign npc_code  = npc_reg;
    assign nsc_code  = nsc_reg;
    assign cih_code  = cih_reg;

endmodule

// File: src/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks on the PLL solver result stream.
// ----------------------------------------------------------------------------
module pps_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          status,
    input  logic [pps_pkg::DIV_W-1:0]     out_div,
    input  logic [pps_pkg::NPC_W-1:0]     npc_code,
    input  logic [pps_pkg::CODE_W-1:0]    nsc_code,
    input  logic [pps_pkg::CODE_W-1:0]    cih_code
);
    import pps_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_div)
            && $stable(npc_code) && $stable(nsc_code) && $stable(cih_code))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_NO_FOUND |->
            out_div == '0 && npc_code == '0 && nsc_code == '0 && cih_code == '0)
        else $error("not-found item carries nonzero fields");

    a_nsc_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_FOUND |-> nsc_code[3:2] == 2'b01)
        else $error("nsc outside 4..7");

    a_cih_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_FOUND |->
            cih_code == CIH_12 || cih_code == CIH_10 || cih_code == CIH_9
            || cih_code == CIH_7 || cih_code == CIH_6 || cih_code == CIH_4
            || cih_code == CIH_3)
        else $error("charge pump code not in band table");

endmodule

bind pll_parameter_solver_top pps_checker u_pps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .out_div   (out_div),
    .npc_code  (npc_code),
    .nsc_code  (nsc_code),
    .cih_code  (cih_code)
);
